@@ rtl/core/aes_block_encrypt_top_macros.svh @@
// assertion macros for the aes block encryption core
// used by aes_block_encrypt_top
`ifndef AES_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/aes_pkg.sv @@
// shared types, constants and gf(2^8) functions for the aes core
// no dependencies
package aes_pkg;
    localparam int BlockBytes = 16;
    localparam logic [7:0] AffineConst = 8'h63;
    localparam logic [7:0] ReduceConst = 8'h1b;

    typedef enum logic [1:0] {
        t_idle  = 2'd0,
        t_init  = 2'd1,
        t_round = 2'd2,
        t_done  = 2'd3
    } t_state;

    typedef enum logic [2:0] {
        CFG_KEY_SIZE = 3'd0,
        CFG_KEY_W0   = 3'd1,
        CFG_KEY_W1   = 3'd2,
        CFG_KEY_W2   = 3'd3,
        CFG_KEY_W3   = 3'd4
    } t_cfg_idx;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? ReduceConst : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) acc = acc ^ x;
            x = xtime(x);
        end
        gf_mul = acc;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] v);
        logic [7:0] acc;
        logic [7:0] sq;
        logic [7:0] s;
        logic [7:0] r;
        acc = 8'h01;
        sq = v;
        for (int n = 0; n < 8; n++) begin
            if (n != 0) acc = gf_mul(acc, sq);
            sq = gf_mul(sq, sq);
        end
        s = acc;
        r = s;
        for (int n = 0; n < 4; n++) begin
            s = {s[6:0], s[7]};
            r = r ^ s;
        end
        sbox_calc = r ^ AffineConst;
    endfunction

    typedef logic [7:0] t_sbox [256];

    function automatic t_sbox sbox_build();
        t_sbox t;
        for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
        sbox_build = t;
    endfunction

    localparam t_sbox SBOX = sbox_build();

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction
endpackage

@@ rtl/core/aes_round.sv @@
// one shared aes round unit: subbytes, shiftrows, optional mixcolumns, addroundkey
// depends on aes_pkg
module aes_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_round_key,
    input  logic         i_last,
    output logic [127:0] o_state
);
    import aes_pkg::*;

    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];

    always_comb begin
        for (int i = 0; i < BlockBytes; i++) sb[i] = SBOX[i_state[127 - 8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) sr[4*c + r] = sb[4*((c + r) % 4) + r];
        for (int c = 0; c < 4; c++) begin
            mc[4*c]     = xtime(sr[4*c]) ^ xtime(sr[4*c+1]) ^ sr[4*c+1]
                          ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c + 1] = sr[4*c] ^ xtime(sr[4*c+1]) ^ xtime(sr[4*c+2])
                          ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c + 2] = sr[4*c] ^ sr[4*c+1] ^ xtime(sr[4*c+2])
                          ^ xtime(sr[4*c+3]) ^ sr[4*c+3];
            mc[4*c + 3] = xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2]
                          ^ xtime(sr[4*c+3]);
        end
        for (int i = 0; i < BlockBytes; i++)
            o_state[127 - 8*i -: 8] = (i_last ? sr[i] : mc[i]) ^ i_round_key[127 - 8*i -: 8];
    end
endmodule

@@ rtl/core/aes_block_encrypt_top.sv @@
// aes ecb encryption core, 128/192/256-bit keys, one round per cycle
// sequence: the idle state captures the block, the init state adds the round 0 key,
// the round state runs rounds 1 to nr and the done state holds the result while i_stall
// is high; new blocks are taken only in the idle state, one block at a time
// reset: synchronous active low, clears the state, key size and key registers to zero
// depends on aes_pkg, aes_round and aes_block_encrypt_top_macros.svh
`include "aes_block_encrypt_top_macros.svh"
module aes_block_encrypt_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low
);
    import aes_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_key_size;
    logic [63:0] r_key [4];
    logic [127:0] r_data;
    logic [31:0] r_win [8];  // schedule words w[i..i+nk-1], oldest first
    logic [31:0] r_pend [4]; // next round key words not yet used, up to four
    logic [2:0] r_pcnt;      // valid words in r_pend
    logic [3:0] r_round;
    logic [7:0] r_rc;
    logic [2:0] r_pos;       // position mod nk of next word to generate
    logic [3:0] nr;
    logic [3:0] nk;

    logic [127:0] rk;
    logic [127:0] rnd_out;
    logic        gen_en;

    always_comb begin
        unique case (r_key_size)
            2'd0:    begin nk = 4'd4; nr = 4'd10; end
            2'd1:    begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
    end

    aes_round u_round (
        .i_state(r_data),
        .i_round_key(rk),
        .i_last(r_round == nr),
        .o_state(rnd_out)
    );

    // generate 4 words per step from the window when r_pend lacks them
    logic [31:0] gw [4];
    logic [31:0] nwin [8];
    logic [7:0]  rc_n;
    logic [2:0]  pos_n;
    always_comb begin
        logic [31:0] t;
        logic [31:0] prev;
        for (int k = 0; k < 8; k++) nwin[k] = r_win[k];
        rc_n = r_rc;
        pos_n = r_pos;
        prev = r_win[3'(nk - 4'd1)];
        for (int j = 0; j < 4; j++) begin
            t = prev;
            if (pos_n == 3'd0) begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rc_n, 24'h0};
                rc_n = xtime(rc_n);
            end else if (nk == 4'd8 && pos_n == 3'd4) begin
                t = sub_word(t);
            end
            gw[j] = nwin[0] ^ t;
            for (int k = 0; k < 7; k++) nwin[k] = nwin[k + 1];
            nwin[3'(nk - 4'd1)] = gw[j];
            prev = gw[j];
            pos_n = (pos_n == 3'(nk - 4'd1)) ? 3'd0 : pos_n + 3'd1;
        end
    end

    // round key: pending words first, then freshly generated ones
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < r_pcnt) rk[127 - 32*j -: 32] = r_pend[j];
            else                rk[127 - 32*j -: 32] = gw[2'(3'(j) - r_pcnt)];
        end
    end
    assign gen_en = (r_pcnt < 3'd4);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle:  if (i_valid) n_state = t_init;
            t_init:  n_state = t_round;
            t_round: if (r_round == nr) n_state = t_done;
            t_done:  if (!i_stall) n_state = t_idle;
            default: n_state = t_idle;
        endcase
    end

    always_comb begin
        o_stall = (r_state != t_idle);
        o_valid = (r_state == t_done);
    end
    assign o_cipher_high = r_data[127:64];
    assign o_cipher_low  = r_data[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_key_size <= 2'd0;
            for (int k = 0; k < 4; k++) r_key[k] <= 64'h0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    CFG_KEY_SIZE: r_key_size <= i_cfg_data[1:0];
                    CFG_KEY_W0:   r_key[0] <= i_cfg_data;
                    CFG_KEY_W1:   r_key[1] <= i_cfg_data;
                    CFG_KEY_W2:   r_key[2] <= i_cfg_data;
                    CFG_KEY_W3:   r_key[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_idle && i_valid) begin
            r_data <= {i_plain_high, i_plain_low};
            for (int k = 0; k < 4; k++) begin
                r_win[2*k]     <= r_key[k][63:32];
                r_win[2*k + 1] <= r_key[k][31:0];
            end
            r_round <= 4'd0;
            r_rc <= 8'h01;
            r_pos <= 3'd0;
            r_pcnt <= 3'd0;
        end else if (r_state == t_init) begin
            // round 0 key is the first four key words
            r_data <= r_data ^ {r_win[0], r_win[1], r_win[2], r_win[3]};
            r_round <= 4'd1;
            if (nk == 4'd4) begin
                r_pcnt <= 3'd0;
            end else begin
                for (int j = 0; j < 4; j++) r_pend[j] <= r_win[4 + j];
                r_pcnt <= 3'(nk - 4'd4);
            end
        end else if (r_state == t_round) begin
            r_data <= rnd_out;
            r_round <= r_round + 4'd1;
            if (gen_en) begin
                for (int k = 0; k < 8; k++) r_win[k] <= nwin[k];
                r_rc <= rc_n;
                r_pos <= pos_n;
                // leftover words of the generated four
                for (int j = 0; j < 4; j++)
                    if (3'(j) < r_pcnt) r_pend[j] <= gw[2'(3'(j) + 3'd4 - r_pcnt)];
                r_pcnt <= r_pcnt;
            end else begin
                r_pcnt <= 3'd0;
            end
        end
    end

    `AES_ASSERT_IMPL(a_valid_done, i_clk, i_rst_n, o_valid, r_round == nr + 4'd1)
    `AES_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != t_idle, o_stall)
    `AES_ASSERT_NEXT(a_accept_init, i_clk, i_rst_n, i_valid && !o_stall, r_state == t_init)
    `AES_ASSERT_IMPL(a_round_range, i_clk, i_rst_n, r_state == t_round, r_round != 4'd0 && r_round <= nr)
endmodule

@@ tb/sv/tb_aes_block_encrypt_top.sv @@
// self-checking testbench for aes_block_encrypt_top, ecb encryption with 128/192/256-bit keys
// predicts ciphertext with its own aes model and compares every returned block
// depends on aes_pkg and the aes_block_encrypt_top rtl
`timescale 1ns / 100ps
module tb_aes_block_encrypt_top;
    import aes_pkg::*;

    localparam int MaxCycles = 2000000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    typedef struct {
        logic [1:0]  ksz;
        logic [63:0] k0, k1, k2, k3;
        logic [63:0] p_hi, p_lo;
        logic        known;
        logic [63:0] c_hi, c_lo;
    } t_vec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_plain_high;
    logic [63:0] i_plain_low;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_cipher_high;
    logic [63:0] o_cipher_low;

    aes_block_encrypt_top uut (.*);

    logic [1:0]  key_len;
    logic [63:0] key_reg [4];
    t_block      cipher_q [$];
    int          err_cnt;
    int          cycle_cnt;
    int          src_idle_pct;
    int          dst_idle_pct;
    t_vec        vecs [$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbyte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] s;
        logic [7:0] r;
        inv = 8'h01;
        for (int n = 0; n < 254; n++) inv = gmul(inv, x);
        r = inv;
        s = inv;
        for (int n = 1; n < 5; n++) begin
            s = {s[6:0], s[7]};
            r ^= s;
        end
        return r ^ 8'h63;
    endfunction

    logic [7:0] sb_tab [256];
    initial for (int i = 0; i < 256; i++) sb_tab[i] = sbyte(8'(i));

    function automatic logic [31:0] subw(input logic [31:0] w);
        return {sb_tab[w[31:24]], sb_tab[w[23:16]], sb_tab[w[15:8]], sb_tab[w[7:0]]};
    endfunction

    function automatic t_block encrypt(input logic [63:0] p_hi, input logic [63:0] p_lo);
        logic [31:0] ks [60];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [7:0]  a0, a1, a2, a3;
        logic [127:0] pt;
        logic [127:0] ct;
        int nk, nr;
        nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            ks[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = ks[i-1];
            if (i % nk == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = subw(t);
            end
            ks[i] = ks[i-nk] ^ t;
        end
        pt = {p_hi, p_lo};
        for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8];
        for (int rd = 0; rd <= nr; rd++) begin
            if (rd > 0) begin
                for (int i = 0; i < 16; i++) st[i] = sb_tab[st[i]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) tmp[4*c+r] = st[4*((c+r)&3)+r];
                st = tmp;
                if (rd != nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        st[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                        st[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                        st[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                        st[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++) st[4*c+j] ^= ks[4*rd+c][31-8*j -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
        return '{hi: ct[127:64], lo: ct[63:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        err_cnt++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_cnt);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KEY_SIZE) key_len = data[1:0];
        else if (idx <= CFG_KEY_W3) key_reg[idx - 1] = data;
    endtask

    task automatic write_bad_index(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] ksz, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(CFG_KEY_SIZE, {62'h0, ksz});
        write_reg(CFG_KEY_W0, k0);
        write_reg(CFG_KEY_W1, k1);
        write_reg(CFG_KEY_W2, k2);
        write_reg(CFG_KEY_W3, k3);
    endtask

    task automatic send_block(input logic [63:0] p_hi, input logic [63:0] p_lo);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_plain_high <= p_hi;
        i_plain_low <= p_lo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cipher_q.push_back(encrypt(p_hi, p_lo));
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    always @(posedge i_clk) begin
        t_block exp_blk;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("unexpected block", o_cipher_high, 64'h0);
            end else begin
                exp_blk = cipher_q.pop_front();
                if (o_cipher_high !== exp_blk.hi)
                    report_mismatch("cipher_high", o_cipher_high, exp_blk.hi);
                if (o_cipher_low !== exp_blk.lo)
                    report_mismatch("cipher_low", o_cipher_low, exp_blk.lo);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MaxCycles) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("aes_block_encrypt_top regression: fail");
            $finish;
        end
    end

    initial begin
        t_vec v;
        t_block got;
        logic [1:0] ksz;
        int n_items;
        cycle_cnt = 0;
        err_cnt = 0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        key_len = 2'd0;
        for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_KEY_SIZE;
        i_cfg_data = 64'h0;
        i_valid = 1'b0;
        i_plain_high = 64'h0;
        i_plain_low = 64'h0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // known answers: fips-197 appendix c and all-zero key after reset
        vecs.push_back('{2'd0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
                         1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
        vecs.push_back('{2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0,
                         64'h0011223344556677, 64'h8899aabbccddeeff,
                         1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
        vecs.push_back('{2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                         64'h1011121314151617, 64'hffffffffffffffff,
                         64'h0011223344556677, 64'h8899aabbccddeeff,
                         1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191});
        vecs.push_back('{2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                         64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                         64'h0011223344556677, 64'h8899aabbccddeeff,
                         1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
        vecs.push_back('{2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                         64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                         64'h0011223344556677, 64'h8899aabbccddeeff,
                         1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
        for (int s = 0; s < 4; s++) begin
            vecs.push_back('{2'(s), '1, '1, '1, '1, '1, '1, 1'b0, 64'h0, 64'h0});
            vecs.push_back('{2'(s), '1, '1, '1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
            vecs.push_back('{2'(s), 64'h0, 64'h0, '1, '1, 64'h8000000000000001,
                             64'h0123456789abcdef, 1'b0, 64'h0, 64'h0});
        end

        foreach (vecs[i]) begin
            v = vecs[i];
            wait_drained();
            load_key(v.ksz, v.k0, v.k1, v.k2, v.k3);
            if (i == 1) write_bad_index(3'd5, '1);
            if (i == 2) write_bad_index(3'd7, 64'h1234);
            if (v.known) begin
                got = encrypt(v.p_hi, v.p_lo);
                if (got.hi !== v.c_hi || got.lo !== v.c_lo)
                    report_mismatch("known answer", got.hi, v.c_hi);
            end
            send_block(v.p_hi, v.p_lo);
        end

        n_items = 0;
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
            dst_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
            for (int k = 0; k < 6; k++) begin
                wait_drained();
                ksz = (k < 4) ? 2'(k) : 2'($urandom_range(3));
                load_key(ksz, rand64(), rand64(), rand64(), rand64());
                if ($urandom_range(3) == 0) write_bad_index(3'($urandom_range(7, 5)), rand64());
                for (int j = 0; j < 78; j++) begin
                    if (j == 40 && k == 2) wait_drained();
                    send_block(rand64(), rand64());
                    n_items++;
                end
            end
        end

        i_valid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("aes_block_encrypt_top regression: pass");
        end else begin
            $display("aes_block_encrypt_top regression: fail");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes_block_encrypt_top.sv
tb/sv/tb_aes_block_encrypt_top.sv
